// File: hdl/qte_pkg.sv
`default_nettype none

package qte_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANG_W = 16;
    localparam int PROD_W = 32;
    localparam int SUM_W = 34;
    localparam int MAG_W = 28;
    localparam int SQ_W = 57;
    localparam int ISQ_STEPS = 29;
    localparam int CW = 36;
    localparam int ACC_W = 34;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;
    localparam int LANES = 3;
    localparam int LANE_PITCH = 0;
    localparam int LANE_YAW_Y = 1;
    localparam int LANE_YAW_Z = 2;

    localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(1) <<< 28;
    localparam logic signed [ACC_W-1:0] HALF_PI_ACC = ACC_W'(1) <<< 30;
    localparam logic signed [ACC_W-1:0] BAM_ROUND = ACC_W'(1) <<< 15;
    localparam logic signed [ANG_W-1:0] QUARTER_BAM = 16'sd16384;
    localparam logic [SQ_W-1:0] RAD_ONE = SQ_W'(1) << 56;

    typedef struct packed {
        logic signed [SUM_W-1:0] sz;
        logic signed [SUM_W-1:0] cz;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cy;
        logic signed [SUM_W-1:0] sp;
        logic [SQ_W-1:0]         rad;
        logic                    clamp;
        logic                    clamp_neg;
    } work_t;

    typedef struct packed {
        work_t           w;
        logic [SQ_W-1:0] res;
    } sq_t;

    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ACC_W-1:0] acc;
        logic                    zero;
    } lane_t;

    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'h20000000;
            1: v = 32'h12E4051E;
            2: v = 32'h09FB385B;
            3: v = 32'h051111D4;
            4: v = 32'h028B0D43;
            5: v = 32'h0145D7E1;
            6: v = 32'h00A2F61E;
            7: v = 32'h00517C55;
            8: v = 32'h0028BE53;
            9: v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/qte_in_if.sv
`default_nettype none

interface qte_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

`default_nettype wire

// File: hdl/qte_out_if.sv
`default_nettype none

interface qte_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic               pitch_clamped;

    modport source (output valid, output angle_x, output angle_y, output angle_z,
                    output pitch_clamped, input ready);
    modport sink (input valid, input angle_x, input angle_y, input angle_z,
                  input pitch_clamped, output ready);
endinterface

`default_nettype wire

// File: hdl/qte_front.sv
`default_nettype none

module qte_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    qte_in_if.sink             quat,
    output logic               wr_valid,
    input  wire logic          wr_ready,
    output qte_pkg::work_t     wr_data
);
    import qte_pkg::*;

    logic en;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    logic signed [PROD_W-1:0] wz_reg, xy_reg, yy_reg, zz_reg, wy_reg;
    logic signed [PROD_W-1:0] zx_reg, xx_reg, wx_reg, yz_reg;

    logic signed [SUM_W-1:0] sz_next, cz_next, sy_next, cy_next, sp_next;
    logic signed [SUM_W-1:0] sz_reg, cz_reg, sy_reg, cy_reg, sp_reg;
    logic                    clamp_next, clamp_reg, neg_reg;
    logic signed [SUM_W-1:0] abs_sp;
    logic [MAG_W-1:0]        mag_reg;

    work_t out_reg;

    function automatic logic signed [SUM_W-1:0] dbl_sum(
        input logic signed [PROD_W-1:0] a,
        input logic signed [PROD_W-1:0] b,
        input logic                     sub
    );
        logic signed [SUM_W-1:0] ea, eb, s;
        ea = SUM_W'(a);
        eb = SUM_W'(b);
        s = sub ? (ea - eb) : (ea + eb);
        return s <<< 1;
    endfunction

    assign en = !s3_valid_reg || wr_ready;
    assign quat.ready = en;

    always_comb
    begin
        sz_next = dbl_sum(wz_reg, xy_reg, 1'b0);
        cz_next = ONE_Q28 - dbl_sum(yy_reg, zz_reg, 1'b0);
        sy_next = dbl_sum(wy_reg, zx_reg, 1'b0);
        cy_next = ONE_Q28 - dbl_sum(xx_reg, yy_reg, 1'b0);
        sp_next = dbl_sum(wx_reg, yz_reg, 1'b1);
        clamp_next = (sp_next >= ONE_Q28) || (sp_next <= -ONE_Q28);
        abs_sp = sp_next[SUM_W-1] ? -sp_next : sp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= quat.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wz_reg <= quat.quat_w * quat.quat_z;
            xy_reg <= quat.quat_x * quat.quat_y;
            yy_reg <= quat.quat_y * quat.quat_y;
            zz_reg <= quat.quat_z * quat.quat_z;
            wy_reg <= quat.quat_w * quat.quat_y;
            zx_reg <= quat.quat_z * quat.quat_x;
            xx_reg <= quat.quat_x * quat.quat_x;
            wx_reg <= quat.quat_w * quat.quat_x;
            yz_reg <= quat.quat_y * quat.quat_z;

            sz_reg <= sz_next;
            cz_reg <= cz_next;
            sy_reg <= sy_next;
            cy_reg <= cy_next;
            sp_reg <= sp_next;
            clamp_reg <= clamp_next;
            neg_reg <= sp_next[SUM_W-1];
            mag_reg <= abs_sp[MAG_W-1:0];

            out_reg.sz <= sz_reg;
            out_reg.cz <= cz_reg;
            out_reg.sy <= sy_reg;
            out_reg.cy <= cy_reg;
            out_reg.sp <= sp_reg;
            out_reg.rad <= RAD_ONE - SQ_W'(mag_reg * mag_reg);
            out_reg.clamp <= clamp_reg;
            out_reg.clamp_neg <= neg_reg;
        end
    end

    assign wr_valid = s3_valid_reg;
    assign wr_data = out_reg;

endmodule

`default_nettype wire

// File: hdl/qte_queue.sv
`default_nettype none

module qte_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire qte_pkg::work_t wr_data,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output qte_pkg::work_t      rd_data
);
    import qte_pkg::*;

    work_t             mem_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push, pop;

    assign wr_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

`default_nettype wire

// File: hdl/qte_back.sv
`default_nettype none

module qte_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           rd_valid,
    output logic                rd_ready,
    input  wire qte_pkg::work_t rd_data,
    qte_out_if.source           euler
);
    import qte_pkg::*;

    localparam int VLD_N = ISQ_STEPS + 1 + CORDIC_STEPS + 1;

    logic             en;
    logic [VLD_N-1:0] vld_reg;
    logic             out_valid_reg;

    sq_t   sq_reg [0:ISQ_STEPS];
    lane_t cd_reg [0:CORDIC_STEPS][0:LANES-1];
    logic  cd_clamp_reg [0:CORDIC_STEPS];
    logic  cd_neg_reg [0:CORDIC_STEPS];

    logic signed [ANG_W-1:0] ax_reg, ay_reg, az_reg;
    logic                    clamped_reg;

    function automatic lane_t pre_rotate(
        input logic signed [SUM_W-1:0] yi,
        input logic signed [SUM_W-1:0] xi
    );
        lane_t l;
        logic signed [CW-1:0] x, y;
        x = CW'(xi);
        y = CW'(yi);
        l.zero = (x == '0) && (y == '0);
        l.acc = '0;
        l.x = x;
        l.y = y;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                l.x = y;
                l.y = -x;
                l.acc = HALF_PI_ACC;
            end
            else
            begin
                l.x = -y;
                l.y = x;
                l.acc = -HALF_PI_ACC;
            end
        end
        return l;
    endfunction

    function automatic logic signed [ANG_W-1:0] to_bam(input lane_t l);
        logic signed [ACC_W-1:0] s;
        s = l.acc + BAM_ROUND;
        return l.zero ? '0 : s[31:16];
    endfunction

    assign en = !out_valid_reg || euler.ready;
    assign rd_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[VLD_N-2:0], rd_valid};
            out_valid_reg <= vld_reg[VLD_N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0].w <= rd_data;
            sq_reg[0].res <= '0;
        end
    end

    for (genvar k = 0; k < ISQ_STEPS; k++)
    begin : g_isqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ISQ_STEPS - 1 - k));
        logic [SQ_W-1:0] trial;
        sq_t             step;
        assign trial = sq_reg[k].res + BIT;
        always_comb
        begin
            step = sq_reg[k];
            if (sq_reg[k].w.rad >= trial)
            begin
                step.w.rad = sq_reg[k].w.rad - trial;
                step.res = (sq_reg[k].res >> 1) + BIT;
            end
            else
            begin
                step.res = sq_reg[k].res >> 1;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[k+1] <= step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd_reg[0][LANE_PITCH] <= pre_rotate(sq_reg[ISQ_STEPS].w.sp,
                                                SUM_W'(sq_reg[ISQ_STEPS].res));
            cd_reg[0][LANE_YAW_Y] <= pre_rotate(sq_reg[ISQ_STEPS].w.sy,
                                                sq_reg[ISQ_STEPS].w.cy);
            cd_reg[0][LANE_YAW_Z] <= pre_rotate(sq_reg[ISQ_STEPS].w.sz,
                                                sq_reg[ISQ_STEPS].w.cz);
            cd_clamp_reg[0] <= sq_reg[ISQ_STEPS].w.clamp;
            cd_neg_reg[0] <= sq_reg[ISQ_STEPS].w.clamp_neg;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        localparam logic signed [ACC_W-1:0] ANG = ACC_W'(atan_entry(i));
        for (genvar j = 0; j < LANES; j++)
        begin : g_lane
            logic signed [CW-1:0] xs, ys;
            assign xs = cd_reg[i][j].x >>> i;
            assign ys = cd_reg[i][j].y >>> i;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cd_reg[i+1][j].zero <= cd_reg[i][j].zero;
                    if (cd_reg[i][j].y > 0)
                    begin
                        cd_reg[i+1][j].x <= cd_reg[i][j].x + ys;
                        cd_reg[i+1][j].y <= cd_reg[i][j].y - xs;
                        cd_reg[i+1][j].acc <= cd_reg[i][j].acc + ANG;
                    end
                    else
                    begin
                        cd_reg[i+1][j].x <= cd_reg[i][j].x - ys;
                        cd_reg[i+1][j].y <= cd_reg[i][j].y + xs;
                        cd_reg[i+1][j].acc <= cd_reg[i][j].acc - ANG;
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cd_clamp_reg[i+1] <= cd_clamp_reg[i];
                cd_neg_reg[i+1] <= cd_neg_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cd_clamp_reg[CORDIC_STEPS])
            begin
                ax_reg <= cd_neg_reg[CORDIC_STEPS] ? -QUARTER_BAM : QUARTER_BAM;
            end
            else
            begin
                ax_reg <= to_bam(cd_reg[CORDIC_STEPS][LANE_PITCH]);
            end
            ay_reg <= to_bam(cd_reg[CORDIC_STEPS][LANE_YAW_Y]);
            az_reg <= to_bam(cd_reg[CORDIC_STEPS][LANE_YAW_Z]);
            clamped_reg <= cd_clamp_reg[CORDIC_STEPS];
        end
    end

    assign euler.valid = out_valid_reg;
    assign euler.angle_x = ax_reg;
    assign euler.angle_y = ay_reg;
    assign euler.angle_z = az_reg;
    assign euler.pitch_clamped = clamped_reg;

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_clamp_angle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && clamped_reg |-> ax_reg == QUARTER_BAM || ax_reg == -QUARTER_BAM)
        else $error("clamped pitch is not a quarter turn");

    a_pitch_root: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ISQ_STEPS] && !sq_reg[ISQ_STEPS].w.clamp
        |-> sq_reg[ISQ_STEPS].res <= (SQ_W'(1) << 28))
        else $error("square root above one");

endmodule

`default_nettype wire

// File: hdl/quaternion_to_euler.sv
`default_nettype none
// Converts a rotation quaternion into three Euler angles.
// The input channel quat carries w, x, y and z in signed Q2.14, and the output
// channel euler carries angle_x, angle_y and angle_z in binary angle units, where
// 32768 equals pi, with pitch_clamped for an asin argument of magnitude one or more.
// A transfer takes place on a clock edge with valid and ready both high.
// Unless stalled, one quaternion can be accepted and one result leave every cycle.
// The path from the input transfer to the result runs through the three front-end
// stages, the queue, the back-end input register, the 29 stages of the square root,
// one quadrant stage, one stage per CORDIC step and the output register.
// The front end and the back end are joined by a four-entry queue.
// When the receiver stalls, the back end holds its stages and the queue fills.
// After that, the front end holds its stages and quat.ready drops.
// The asynchronous reset clears every valid flag and the queue, so no result is
// pending when it is released.
module quaternion_to_euler (
    input  wire logic clk,
    input  wire logic rst_n,
    qte_in_if.sink    quat,
    qte_out_if.source euler
);
    import qte_pkg::*;

    logic  f_valid, f_ready, b_valid, b_ready;
    work_t f_data, b_data;

    qte_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .quat     (quat),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data)
    );

    qte_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    qte_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data),
        .euler    (euler)
    );

endmodule

`default_nettype wire

// File: verif/qte_checker.sv
`default_nettype none

module qte_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    qte_in_if.sink      quat,
    qte_out_if.sink     euler,
    output int          fail_count,
    output int          pending_count
);
    import qte_pkg::*;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic               clamped;
    } euler_t;

    euler_t angles_due[$];

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(longint sy, longint sx);
        longint acc;
        longint t;
        longint xs;
        longint ys;
        acc = 0;
        if (sx == 0 && sy == 0)
            return 0;
        if (sx < 0)
        begin
            if (sy >= 0)
            begin
                t = sx; sx = sy; sy = -t; acc = 64'sd1 <<< 30;
            end
            else
            begin
                t = sx; sx = -sy; sy = t; acc = -(64'sd1 <<< 30);
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            xs = shr_floor(sx, i);
            ys = shr_floor(sy, i);
            if (sy > 0)
            begin
                sx = sx + ys; sy = sy - xs; acc = acc + longint'(atan_entry(i));
            end
            else
            begin
                sx = sx - ys; sy = sy + xs; acc = acc - longint'(atan_entry(i));
            end
        end
        return acc;
    endfunction

    function automatic logic [15:0] to_bam(longint acc);
        longint r;
        r = shr_floor(acc + (64'sd1 <<< 15), 16);
        return r[15:0];
    endfunction

    function automatic euler_t convert(longint w, longint x, longint y, longint z);
        euler_t e;
        longint one;
        longint sz;
        longint cz;
        longint sy;
        longint cy;
        longint sp;
        longint mag;
        one = 64'sd1 <<< 28;
        sz = 2 * (w * z + x * y);
        cz = one - 2 * (y * y + z * z);
        sy = 2 * (w * y + z * x);
        cy = one - 2 * (x * x + y * y);
        sp = 2 * (w * x - y * z);
        e.clamped = 1'b0;
        if (sp >= one)
        begin
            e.ax = 16'sd16384; e.clamped = 1'b1;
        end
        else if (sp <= -one)
        begin
            e.ax = -16'sd16384; e.clamped = 1'b1;
        end
        else
        begin
            mag = sp < 0 ? -sp : sp;
            e.ax = to_bam(vector_angle(sp, root_floor((64'd1 << 56) - mag * mag)));
        end
        e.ay = to_bam(vector_angle(sy, cy));
        e.az = to_bam(vector_angle(sz, cz));
        return e;
    endfunction

    assign pending_count = angles_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        euler_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            angles_due.delete();
        end
        else
        begin
            if (quat.valid && quat.ready)
                angles_due.insert(angles_due.size(),
                                  convert(quat.quat_w, quat.quat_x, quat.quat_y,
                                          quat.quat_z));
            if (euler.valid && euler.ready)
            begin
                if (angles_due.size() == 0)
                begin
                    $display("%0t: result transfer with none expected", $time);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = angles_due.pop_front();
                    if (euler.angle_x !== e.ax || euler.angle_y !== e.ay ||
                        euler.angle_z !== e.az || euler.pitch_clamped !== e.clamped)
                    begin
                        $display("%0t: expected x=%0d y=%0d z=%0d c=%0b, %s",
                                 $time, e.ax, e.ay, e.az, e.clamped, "actual");
                        $display("%0t: actual x=%0d y=%0d z=%0d c=%0b",
                                 $time, euler.angle_x, euler.angle_y,
                                 euler.angle_z, euler.pitch_clamped);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

`default_nettype wire

// File: verif/tb_quaternion_to_euler.sv
`default_nettype none

module tb_quaternion_to_euler;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    int   ready_wait = 0;
    int   ready_draw;

    qte_in_if  quat ();
    qte_out_if euler ();

    quaternion_to_euler dut (.clk(clk), .rst_n(rst_n), .quat(quat.sink),
                             .euler(euler.source));

    qte_checker checker_i (.clk(clk), .rst_n(rst_n), .quat(quat.sink),
                           .euler(euler.sink), .fail_count(fail_count),
                           .pending_count(pending_count));

    always #10 clk = ~clk;

    initial
    begin
        quat.valid = 1'b0;
        quat.quat_w = '0;
        quat.quat_x = '0;
        quat.quat_y = '0;
        quat.quat_z = '0;
        euler.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // After each result transfer the receiver draws how many cycles it holds ready low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!euler.ready)
            begin
                if (ready_wait <= 1)
                    euler.ready <= 1'b1;
                ready_wait <= ready_wait - 1;
            end
            else if (euler.valid)
            begin
                ready_draw = $urandom_range(0, 7);
                ready_wait <= ready_draw;
                if (ready_draw != 0)
                    euler.ready <= 1'b0;
            end
        end
    end

    function automatic logic [15:0] unit_part(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 32768)) - 16384);
            2: return 16'($signed($urandom_range(0, 23170)) - 11585);
            default: return 16'($signed($urandom_range(0, 16)) - 8);
        endcase
    endfunction

    task automatic send(input logic [15:0] w, input logic [15:0] x,
                        input logic [15:0] y, input logic [15:0] z, input int gap);
        if (gap > 0)
        begin
            quat.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        quat.valid  <= 1'b1;
        quat.quat_w <= w;
        quat.quat_x <= x;
        quat.quat_y <= y;
        quat.quat_z <= z;
        @(posedge clk);
        while (!quat.ready)
            @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] v[4];
        int gap;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 0);
        send(16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
        send(16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 0);
        send(16'sd11585, -16'sd11585, 16'sd0, 16'sd0, 0);
        send(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1);
        send(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 0);
        send(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 0);
        send(16'sd0, 16'sd0, 16'sd0, -16'sd16384, 2);
        send(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
        send(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
        send(16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 0);
        send(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 0);
        send(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192, 0);
        send(16'sd0, 16'sd11585, 16'sd11585, 16'sd0, 0);
        send(16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 0);
        send(16'sd11585, 16'sd0, 16'sd0, -16'sd11585, 0);
        send(16'sd1, 16'sd1, 16'sd1, 16'sd1, 0);
        send(16'hffff, 16'hffff, 16'hffff, 16'hffff, 0);
        for (int n = 0; n < 1630; n++)
        begin
            for (int k = 0; k < 4; k++)
                v[k] = unit_part($urandom_range(0, 3));
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (n == 800)
            begin
                quat.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_count != 0);
            end
            send(v[0], v[1], v[2], v[3], gap);
        end
        quat.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

`default_nettype wire
